// ===== src/rfcr_pkg.sv =====
// Shared widths, constants and the pipeline word type of the complex rotator.
package rfcr_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int ANGLE_BITS      = 24;
  localparam int ROTATION_STAGES = 18;

  localparam int TIME_W   = 32;
  localparam int RATE_W   = 32;
  localparam int PHASE_W  = 24;
  localparam int CFG_W    = 32;
  localparam int TURN_W   = 32;
  localparam int OUT_W    = SAMPLE_BITS + 1;
  localparam int FRAC_W   = 24;
  localparam int XW       = SAMPLE_BITS + FRAC_W + 4;
  localparam int ZW       = TURN_W + 2;
  localparam int STAGE_W  = 5;

  // Configuration register indexes
  localparam logic REG_TURN_RATE    = 1'b0;
  localparam logic REG_PHASE_OFFSET = 1'b1;

  // Inverse CORDIC gain in Q24
  localparam logic signed [XW-1:0] GAIN_Q24 = XW'(10188014);
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'd1073741824);
  localparam logic [TURN_W-1:0] ANGLE_KEEP = ~(TURN_W'(0)) << (TURN_W - ANGLE_BITS);

  // Arctangent of 2^-i in units of 2^-32 turn
  localparam logic [TURN_W-1:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                 valid;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

endpackage

// ===== src/rfcr_front.sv =====
// Front end: phase multiply, gain scaling, angle sum and quarter-turn pre-rotation.
module rfcr_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 take,
  input  logic signed [rfcr_pkg::TIME_W-1:0]   sample_time,
  input  logic signed [rfcr_pkg::SAMPLE_BITS-1:0] lab_real,
  input  logic signed [rfcr_pkg::SAMPLE_BITS-1:0] lab_imag,
  input  logic signed [rfcr_pkg::RATE_W-1:0]   turn_rate,
  input  logic        [rfcr_pkg::PHASE_W-1:0]  phase_offset,
  output rfcr_pkg::vec_t                       vec
);

  logic                                  a_valid;
  logic signed [63:0]                    prod;
  logic signed [rfcr_pkg::XW-1:0]        xg;
  logic signed [rfcr_pkg::XW-1:0]        yg;

  logic [rfcr_pkg::TURN_W-1:0]           a_time;
  logic [rfcr_pkg::TURN_W-1:0]           a_phase;
  logic [rfcr_pkg::TURN_W-1:0]           theta;
  logic [rfcr_pkg::TURN_W-1:0]           neg;
  logic signed [rfcr_pkg::ZW-1:0]        z0;
  rfcr_pkg::vec_t                        vec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= take;
    end
    prod <= 64'(turn_rate) * 64'(sample_time);
    xg   <= rfcr_pkg::XW'(lab_real) * rfcr_pkg::GAIN_Q24;
    yg   <= rfcr_pkg::XW'(lab_imag) * rfcr_pkg::GAIN_Q24;
  end

  always_comb begin
    a_time  = prod[39:8] & rfcr_pkg::ANGLE_KEEP;
    a_phase = {phase_offset, 8'b0} & rfcr_pkg::ANGLE_KEEP;
    theta   = a_time + a_phase;
    neg     = rfcr_pkg::TURN_W'(0) - theta;
    z0      = rfcr_pkg::ZW'($signed(neg));
    vec_next.valid = a_valid;
    if (z0 > rfcr_pkg::QUARTER_TURN) begin
      vec_next.x = -yg;
      vec_next.y = xg;
      vec_next.z = z0 - rfcr_pkg::QUARTER_TURN;
    end else if (z0 < -rfcr_pkg::QUARTER_TURN) begin
      vec_next.x = yg;
      vec_next.y = -xg;
      vec_next.z = z0 + rfcr_pkg::QUARTER_TURN;
    end else begin
      vec_next.x = xg;
      vec_next.y = yg;
      vec_next.z = z0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec.valid <= 1'b0;
    end else begin
      vec.valid <= vec_next.valid;
    end
    vec.x <= vec_next.x;
    vec.y <= vec_next.y;
    vec.z <= vec_next.z;
  end

endmodule

// ===== src/rfcr_cell.sv =====
// One CORDIC shift-add cell with its output register.
module rfcr_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [rfcr_pkg::STAGE_W-1:0]    stage,
  input  rfcr_pkg::vec_t                  vin,
  output rfcr_pkg::vec_t                  vout
);

  logic signed [rfcr_pkg::XW-1:0] x;
  logic signed [rfcr_pkg::XW-1:0] y;
  logic signed [rfcr_pkg::ZW-1:0] z;
  logic signed [rfcr_pkg::XW-1:0] dx;
  logic signed [rfcr_pkg::XW-1:0] dy;
  logic signed [rfcr_pkg::ZW-1:0] step;
  rfcr_pkg::vec_t                 vout_next;

  always_comb begin
    x    = vin.x;
    y    = vin.y;
    z    = vin.z;
    dx   = y >>> stage;
    dy   = x >>> stage;
    step = $signed(rfcr_pkg::ZW'(rfcr_pkg::ATAN_TURNS[stage]));
    vout_next.valid = vin.valid;
    if (!z[rfcr_pkg::ZW-1]) begin
      vout_next.x = x - dx;
      vout_next.y = y + dy;
      vout_next.z = z - step;
    end else begin
      vout_next.x = x + dx;
      vout_next.y = y - dy;
      vout_next.z = z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout.valid <= 1'b0;
    end else begin
      vout.valid <= vout_next.valid;
    end
    vout.x <= vout_next.x;
    vout.y <= vout_next.y;
    vout.z <= vout_next.z;
  end

endmodule

// ===== src/rfcr_out.sv =====
// Output stage: round to nearest, clamp and register the result word.
module rfcr_out (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rfcr_pkg::vec_t                       vin,
  output logic                                 done,
  output logic signed [rfcr_pkg::OUT_W-1:0]    frame_real,
  output logic signed [rfcr_pkg::OUT_W-1:0]    frame_imag
);

  localparam int RW = rfcr_pkg::XW - rfcr_pkg::FRAC_W;
  localparam logic signed [RW-1:0] OUT_MAX = RW'((64'sd1 <<< rfcr_pkg::SAMPLE_BITS) - 1);
  localparam logic signed [RW-1:0] OUT_MIN = RW'(-(64'sd1 <<< rfcr_pkg::SAMPLE_BITS));
  localparam logic signed [rfcr_pkg::XW-1:0] HALF = rfcr_pkg::XW'(64'sd1 <<< (rfcr_pkg::FRAC_W - 1));

  logic signed [rfcr_pkg::XW-1:0] x;
  logic signed [rfcr_pkg::XW-1:0] y;
  logic signed [rfcr_pkg::XW-1:0] xr;
  logic signed [rfcr_pkg::XW-1:0] yr;
  logic signed [RW-1:0]           xs;
  logic signed [RW-1:0]           ys;
  logic signed [rfcr_pkg::OUT_W-1:0] real_next;
  logic signed [rfcr_pkg::OUT_W-1:0] imag_next;

  always_comb begin
    x  = vin.x;
    y  = vin.y;
    xr = (x + HALF) >>> rfcr_pkg::FRAC_W;
    yr = (y + HALF) >>> rfcr_pkg::FRAC_W;
    xs = xr[RW-1:0];
    ys = yr[RW-1:0];
    if (xs > OUT_MAX) begin
      real_next = OUT_MAX[rfcr_pkg::OUT_W-1:0];
    end else if (xs < OUT_MIN) begin
      real_next = OUT_MIN[rfcr_pkg::OUT_W-1:0];
    end else begin
      real_next = xs[rfcr_pkg::OUT_W-1:0];
    end
    if (ys > OUT_MAX) begin
      imag_next = OUT_MAX[rfcr_pkg::OUT_W-1:0];
    end else if (ys < OUT_MIN) begin
      imag_next = OUT_MIN[rfcr_pkg::OUT_W-1:0];
    end else begin
      imag_next = ys[rfcr_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vin.valid;
    end
    frame_real <= real_next;
    frame_imag <= imag_next;
  end

endmodule

// ===== src/rotating_frame_complex_rotator.sv =====
// Top level of the rotating-frame complex rotator.
//
// Usage:
//   Input channel: drive sample_time, lab_real and lab_imag and raise start;
//   the word is taken at a rising edge with start high and busy low. busy
//   stays low, so a new word may be offered on every clock.
//   Result channel: done is high for exactly one cycle with frame_real and
//   frame_imag; the receiver must take the word in that cycle.
//   Configuration: write turn_rate (index 0) or phase_offset (index 1) with
//   cfg_we, cfg_index and cfg_data, only while no word is in flight.
//   Pipeline: one multiply stage, one angle and pre-rotation stage, one
//   registered stage per CORDIC cell (18 cells) and one rounding stage.
//   Throughput: one word per clock, set by the row of CORDIC cells, each of
//   which passes its vector and residual angle to the next every cycle.
//   Reset: synchronous rst clears both registers to zero and drops every word
//   in flight; no done pulse appears for words taken before reset.
//   Stall: the receiver cannot hold results off, so the pipeline never stops.
module rotating_frame_complex_rotator (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [rfcr_pkg::TIME_W-1:0]      sample_time,
  input  logic signed [rfcr_pkg::SAMPLE_BITS-1:0] lab_real,
  input  logic signed [rfcr_pkg::SAMPLE_BITS-1:0] lab_imag,
  output logic                                    done,
  output logic signed [rfcr_pkg::OUT_W-1:0]       frame_real,
  output logic signed [rfcr_pkg::OUT_W-1:0]       frame_imag,
  input  logic                                    cfg_we,
  input  logic                                    cfg_index,
  input  logic [rfcr_pkg::CFG_W-1:0]              cfg_data
);

  logic signed [rfcr_pkg::RATE_W-1:0]  turn_rate;
  logic        [rfcr_pkg::PHASE_W-1:0] phase_offset;
  logic                                take;

  rfcr_pkg::vec_t chain [rfcr_pkg::ROTATION_STAGES + 1];

  // The pipeline never fills up, so the input is always open
  assign busy = 1'b0;
  assign take = start & ~busy;

  // Hold the configuration registers; drop bits above each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_rate    <= '0;
      phase_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rfcr_pkg::REG_TURN_RATE:    turn_rate    <= cfg_data[rfcr_pkg::RATE_W-1:0];
        rfcr_pkg::REG_PHASE_OFFSET: phase_offset <= cfg_data[rfcr_pkg::PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Form the angle and pre-rotate the gain-scaled sample into the CORDIC range
  rfcr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .sample_time  (sample_time),
    .lab_real     (lab_real),
    .lab_imag     (lab_imag),
    .turn_rate    (turn_rate),
    .phase_offset (phase_offset),
    .vec          (chain[0])
  );

  // Advance each word through the row of registered shift-add cells
  for (genvar i = 0; i < rfcr_pkg::ROTATION_STAGES; i++) begin : g_cell
    rfcr_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .stage (rfcr_pkg::STAGE_W'(i)),
      .vin   (chain[i]),
      .vout  (chain[i+1])
    );
  end

  // Round, clamp and present the result word for one cycle
  rfcr_out u_out (
    .clk        (clk),
    .rst        (rst),
    .vin        (chain[rfcr_pkg::ROTATION_STAGES]),
    .done       (done),
    .frame_real (frame_real),
    .frame_imag (frame_imag)
  );

endmodule
